// ===== design/swdr_pkg.sv =====
// Shared types and constants for the sliding-window damage sum.
// No dependencies.
package swdr_pkg;

    localparam int EVENT_DEPTH_DEF = 16;
    localparam int WINDOW_RESET    = 1000;
    localparam int HP_W            = 16;
    localparam int TIME_W          = 32;
    localparam int WIN_W           = 16;
    localparam int SUM_W           = 22;
    localparam int HELD_W          = 7;
    localparam int KIND_W          = 1;
    localparam int S_DATA_W        = 48;
    localparam int M_DATA_W        = 32;
    localparam int APB_ADDR_W      = 3;
    localparam int APB_DATA_W      = 32;

    localparam logic [KIND_W-1:0] KIND_STATUS = 1'b1;
    localparam logic              REG_WINDOW  = 1'b0;

    typedef struct packed {
        logic [HP_W-1:0]   amount;
        logic [TIME_W-1:0] stamp;
    } event_t;

    typedef struct packed {
        logic shift;
        logic load;
    } cell_ctrl_t;

endpackage

// ===== design/swdr_cell.sv =====
// One slot of the event chain: loads a new event or takes its right neighbor's.
// Depends on swdr_pkg.
module swdr_cell (
    input  logic                aclk,
    input  swdr_pkg::cell_ctrl_t ctrl,
    input  swdr_pkg::event_t    new_event,
    input  swdr_pkg::event_t    neighbor,
    output swdr_pkg::event_t    slot
);
    import swdr_pkg::*;

    event_t slot_reg;
    event_t slot_next;

    always_comb begin
        slot_next = slot_reg;
        if (ctrl.load) begin
            slot_next = new_event;
        end else if (ctrl.shift) begin
            slot_next = neighbor;
        end
    end

    always_ff @(posedge aclk) begin
        slot_reg <= slot_next;
    end

    assign slot = slot_reg;

endmodule

// ===== design/sliding_window_damage_rate.sv =====
// Top level of the sliding-window damage sum: control, running sum and the cell chain.
// Depends on swdr_pkg and swdr_cell.
//
// Each request carries a timestamp and, for status reports, a hit-point value. Damage
// events sit in a chain of EVENT_DEPTH cells, oldest at the front; expired events leave
// one per cycle as the chain shifts forward, then a new event is loaded.
// A request passes through EXPIRE, then APPEND when damage is appended, then DONE; the
// result sits in an output register, so the next request is taken while it waits.
module sliding_window_damage_rate #(
    parameter int EVENT_DEPTH = swdr_pkg::EVENT_DEPTH_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [swdr_pkg::S_DATA_W-1:0]     s_tdata,   // now_ms[31:0], current_hp[47:32]
    input  logic [swdr_pkg::KIND_W-1:0]       s_tuser,   // kind[0]
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [swdr_pkg::M_DATA_W-1:0]     m_tdata,   // damage_sum[21:0], events_held[28:22]
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [swdr_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [swdr_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [swdr_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import swdr_pkg::*;

    localparam int CNT_W = $clog2(EVENT_DEPTH + 1);

    typedef enum logic [1:0] {IDLE, EXPIRE, APPEND, DONE} state_t;

    state_t               state_reg, state_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [SUM_W-1:0]     sum_reg, sum_next;
    logic [HP_W-1:0]      last_hp_reg, last_hp_next;
    logic [WIN_W-1:0]     window_reg, window_next;
    logic [KIND_W-1:0]    kind_reg, kind_next;
    logic [TIME_W-1:0]    now_reg, now_next;
    logic [HP_W-1:0]      hp_reg, hp_next;
    logic [HP_W-1:0]      amount_reg, amount_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg, m_tdata_next;

    event_t               cells [EVENT_DEPTH];
    event_t               new_event;
    cell_ctrl_t           ctrl [EVENT_DEPTH];
    logic                 shift_all;
    logic                 full;
    logic                 expire_hit;
    logic [TIME_W-1:0]    age;
    logic                 cfg_write;

    assign full       = (count_reg == CNT_W'(EVENT_DEPTH));
    assign age        = now_reg - cells[0].stamp;
    assign expire_hit = (count_reg != '0) && (age > {{(TIME_W-WIN_W){1'b0}}, window_reg});
    assign shift_all  = ((state_reg == EXPIRE) && expire_hit) ||
                        ((state_reg == APPEND) && full);
    assign new_event  = '{amount: amount_reg, stamp: now_reg};

    genvar gi;
    generate
        for (gi = 0; gi < EVENT_DEPTH; gi++) begin : g_cell
            event_t nb;
            if (gi == EVENT_DEPTH - 1) begin : g_end
                assign nb = '0;
            end else begin : g_mid
                assign nb = cells[gi+1];
            end
            assign ctrl[gi].shift = shift_all;
            assign ctrl[gi].load  = (state_reg == APPEND) &&
                                    (full ? (gi == EVENT_DEPTH - 1)
                                          : (count_reg == CNT_W'(gi)));
            swdr_cell u_cell (
                .aclk      (aclk),
                .ctrl      (ctrl[gi]),
                .new_event (new_event),
                .neighbor  (nb),
                .slot      (cells[gi])
            );
        end
    endgenerate

    assign cfg_write = psel && penable && pwrite && pready;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == REG_WINDOW) ? {{(APB_DATA_W-WIN_W){1'b0}}, window_reg} : '0;
    assign s_tready  = (state_reg == IDLE);
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    always_comb begin
        state_next    = state_reg;
        count_next    = count_reg;
        sum_next      = sum_reg;
        last_hp_next  = last_hp_reg;
        window_next   = window_reg;
        kind_next     = kind_reg;
        now_next      = now_reg;
        hp_next       = hp_reg;
        amount_next   = amount_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;

        if (cfg_write && (paddr[2] == REG_WINDOW)) begin
            window_next = pwdata[WIN_W-1:0];
        end

        unique case (state_reg)
            IDLE: begin
                if (s_tvalid) begin
                    kind_next  = s_tuser;
                    now_next   = s_tdata[TIME_W-1:0];
                    hp_next    = s_tdata[TIME_W +: HP_W];
                    state_next = EXPIRE;
                end
            end
            EXPIRE: begin
                if (expire_hit) begin
                    count_next = count_reg - 1'b1;
                    sum_next   = sum_reg - {{(SUM_W-HP_W){1'b0}}, cells[0].amount};
                end else begin
                    state_next = DONE;
                    if (kind_reg == KIND_STATUS) begin
                        last_hp_next = hp_reg;
                        amount_next  = last_hp_reg - hp_reg;
                        if (hp_reg < last_hp_reg) begin
                            state_next = APPEND;
                        end
                    end
                end
            end
            APPEND: begin
                if (full) begin
                    sum_next = sum_reg - {{(SUM_W-HP_W){1'b0}}, cells[0].amount}
                                       + {{(SUM_W-HP_W){1'b0}}, amount_reg};
                end else begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + {{(SUM_W-HP_W){1'b0}}, amount_reg};
                end
                state_next = DONE;
            end
            DONE: begin
                if (!m_tvalid_reg || m_tready) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {{(M_DATA_W-SUM_W-HELD_W){1'b0}},
                                     HELD_W'(count_reg), sum_reg};
                    state_next    = IDLE;
                end
            end
            default: state_next = IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= IDLE;
            count_reg    <= '0;
            sum_reg      <= '0;
            last_hp_reg  <= '0;
            window_reg   <= WIN_W'(WINDOW_RESET);
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            count_reg    <= count_next;
            sum_reg      <= sum_next;
            last_hp_reg  <= last_hp_next;
            window_reg   <= window_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        kind_reg    <= kind_next;
        now_reg     <= now_next;
        hp_reg      <= hp_next;
        amount_reg  <= amount_next;
        m_tdata_reg <= m_tdata_next;
    end

endmodule
